@@ hdl/scop_pkg.sv @@
// ----------------------------------------------------------------------------
// scop_pkg
// Shared widths, constants and types of the soft-clip overdrive.
// ----------------------------------------------------------------------------
package scop_pkg;

	localparam int unsigned SMP_W  = 16;
	localparam int unsigned LVL_W  = 7;
	localparam int unsigned MAG_W  = 12;
	localparam int unsigned SQ_W   = 2 * MAG_W;
	localparam int unsigned QUO_W  = 11;
	localparam int unsigned THR_W  = 12;
	localparam int unsigned SCL_W  = 10;
	localparam int unsigned PRD_W  = 24;
	localparam int unsigned RCP_W  = 23;
	localparam int unsigned RCP_SH = 30;

	// Multiplying by ceil(2^30/200) and shifting right by 30 divides any
	// magnitude below 2^22 by 200 exactly.
	localparam logic [RCP_W-1:0] RECIP_200 = 23'd5368710;

	localparam logic [SCL_W-1:0] SCALE_BASE = 10'd200;

	localparam logic [LVL_W-1:0] CLIP_RST = 7'd50;
	localparam logic [LVL_W-1:0] GAIN_RST = 7'd50;

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_CLIP   = 2'd1,
		REG_GAIN   = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                    byp;
		logic signed [SMP_W-1:0] x;
		logic [SQ_W-1:0]         rem;
		logic [SQ_W-1:0]         dvs;
		logic [QUO_W-1:0]        quo;
	} div_beat_t;

endpackage

@@ hdl/soft_clip_overdrive.sv @@
// ----------------------------------------------------------------------------
// soft_clip_overdrive
// Symmetrical soft-clipping overdrive for a stream of 16-bit audio samples.
// ----------------------------------------------------------------------------
// Samples enter on the s_ channel and leave on the m_ channel, one result
// beat for every input beat, in order. The APB port holds enable at 0x0,
// clip level at 0x4 and gain level at 0x8; write them only while no beat is
// in flight. The block takes one beat per cycle while a stage has room, and
// each result passes through one squaring stage, a row of 11 division
// cells that each settle one quotient bit of the knee term, the curve
// stage, the gain multiply, the multiply by the reciprocal of 200, and the
// output register. Every stage has its own valid bit, so a stalled output
// only holds back as many stages as are full, and the input stays ready
// while any stage has room. Reset empties the pipeline and loads enable 0,
// clip 50 and gain 50.
// ----------------------------------------------------------------------------
module soft_clip_overdrive (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] sample_out
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned NC = scop_pkg::QUO_W;

	logic                              enable_q;
	logic [scop_pkg::LVL_W-1:0]        clip_q;
	logic [scop_pkg::LVL_W-1:0]        gain_q;
	scop_pkg::reg_idx_t                idx;

	logic                              v_s1;
	logic signed [scop_pkg::SMP_W-1:0] x_s1;
	logic [scop_pkg::SQ_W-1:0]         sq_s1;
	logic                              byp_s1;
	logic                              free_s1;
	logic [scop_pkg::SMP_W:0]          absx;
	logic [scop_pkg::MAG_W-1:0]        mag;
	logic [scop_pkg::THR_W-1:0]        thr;

	logic                 link_valid [0:NC];
	logic                 link_free  [0:NC];
	scop_pkg::div_beat_t  link_data  [0:NC];

	assign pready = 1'b1;
	assign idx    = scop_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			clip_q   <= scop_pkg::CLIP_RST;
			gain_q   <= scop_pkg::GAIN_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (idx)
				scop_pkg::REG_ENABLE: enable_q <= pwdata[0];
				scop_pkg::REG_CLIP:   clip_q   <= pwdata[scop_pkg::LVL_W-1:0];
				scop_pkg::REG_GAIN:   gain_q   <= pwdata[scop_pkg::LVL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			scop_pkg::REG_ENABLE: prdata = {31'd0, enable_q};
			scop_pkg::REG_CLIP:   prdata = {25'd0, clip_q};
			scop_pkg::REG_GAIN:   prdata = {25'd0, gain_q};
			default:              prdata = 32'd0;
		endcase
	end

	assign absx = s_tdata[15] ? (17'd0 - {1'b1, s_tdata}) : {1'b0, s_tdata};
	assign mag  = absx[scop_pkg::MAG_W-1:0];

	assign free_s1  = ~v_s1 | link_free[0];
	assign s_tready = free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (free_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s1 && s_tvalid) begin
			x_s1   <= s_tdata;
			sq_s1  <= mag * mag;
			byp_s1 <= ~enable_q;
		end
	end

	assign thr = {clip_q, 5'b00000} - {4'b0000, clip_q, 1'b0};

	assign link_valid[0]    = v_s1;
	assign link_data[0].byp = byp_s1;
	assign link_data[0].x   = x_s1;
	assign link_data[0].rem = sq_s1;
	assign link_data[0].dvs = {2'b00, thr, 10'd0};
	assign link_data[0].quo = '0;

	for (genvar i = 0; i < NC; i++) begin : g_cell
		scop_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[i]),
			.in_data   (link_data[i]),
			.in_free   (link_free[i]),
			.out_valid (link_valid[i+1]),
			.out_data  (link_data[i+1]),
			.out_free  (link_free[i+1])
		);
	end

	scop_shape u_shape (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (link_valid[NC]),
		.in_data  (link_data[NC]),
		.in_free  (link_free[NC]),
		.clip     (clip_q),
		.gain     (gain_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

@@ hdl/scop_div_cell.sv @@
// ----------------------------------------------------------------------------
// scop_div_cell
// One restoring division step; cells in a row produce one quotient bit each.
// ----------------------------------------------------------------------------
module scop_div_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  scop_pkg::div_beat_t   in_data,
	output logic                  in_free,
	output logic                  out_valid,
	output scop_pkg::div_beat_t   out_data,
	input  logic                  out_free
);

	logic                valid_q;
	scop_pkg::div_beat_t data_q;
	logic                ge;
	logic [scop_pkg::SQ_W-1:0] rem_next;

	assign in_free   = ~valid_q | out_free;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	assign ge       = in_data.rem >= in_data.dvs;
	assign rem_next = ge ? (in_data.rem - in_data.dvs) : in_data.rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_free) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_free && in_valid) begin
			data_q.byp <= in_data.byp;
			data_q.x   <= in_data.x;
			data_q.rem <= rem_next;
			data_q.dvs <= in_data.dvs >> 1;
			data_q.quo <= {in_data.quo[scop_pkg::QUO_W-2:0], ge};
		end
	end

endmodule

@@ hdl/scop_shape.sv @@
// ----------------------------------------------------------------------------
// scop_shape
// Piecewise clipping curve, gain scaling, division by 200 and output register.
// ----------------------------------------------------------------------------
module scop_shape (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  scop_pkg::div_beat_t           in_data,
	output logic                          in_free,
	input  logic [scop_pkg::LVL_W-1:0]    clip,
	input  logic [scop_pkg::LVL_W-1:0]    gain,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [scop_pkg::SMP_W-1:0]    m_tdata
);

	logic v_sh_q, v_p1_q, v_p2_q, v_out_q;
	logic free_sh, free_p1, free_p2, free_out;

	logic signed [13:0]             y_s1;
	logic                           byp_s1;
	logic signed [scop_pkg::SMP_W-1:0] x_s1;

	logic signed [scop_pkg::PRD_W-1:0] p_s2;
	logic                           byp_s2;
	logic signed [scop_pkg::SMP_W-1:0] x_s2;

	logic [scop_pkg::SMP_W-1:0]     mq_s3;
	logic                           neg_s3;
	logic                           byp_s3;
	logic signed [scop_pkg::SMP_W-1:0] x_s3;

	logic [scop_pkg::SMP_W-1:0]     out_q;

	logic signed [19:0] xs, third, two, thr, qq, y;
	logic [scop_pkg::THR_W-1:0] third_u;
	logic [scop_pkg::SCL_W-1:0] scale;
	logic [scop_pkg::PRD_W-2:0] mag;
	logic [scop_pkg::PRD_W-2+scop_pkg::RCP_W:0] prod;
	logic signed [scop_pkg::SMP_W:0] sv;
	logic [scop_pkg::SMP_W-1:0] sat;

	assign free_out = ~v_out_q | m_tready;
	assign free_p2  = ~v_p2_q | free_out;
	assign free_p1  = ~v_p1_q | free_p2;
	assign free_sh  = ~v_sh_q | free_p1;
	assign in_free  = free_sh;

	assign m_tvalid = v_out_q;
	assign m_tdata  = out_q;

	always_comb begin
		third_u = {2'b00, clip, 3'b000} + {4'b0000, clip, 1'b0};
		xs      = {{4{in_data.x[15]}}, in_data.x};
		third   = {8'd0, third_u};
		two     = third <<< 1;
		thr     = two + third;
		qq      = {9'd0, in_data.quo};
		if (xs <= -two) begin
			y = -thr;
		end else if (xs <= -third) begin
			y = third + (xs <<< 2) + (qq <<< 1) + qq;
		end else if (xs < third) begin
			y = xs <<< 1;
		end else if (xs <= two) begin
			y = -third + (xs <<< 2) - (qq <<< 1) - qq;
		end else begin
			y = thr;
		end
	end

	assign scale = scop_pkg::SCALE_BASE + {2'b00, gain, 1'b0} + {3'b000, gain};
	assign mag   = p_s2[scop_pkg::PRD_W-1] ? (scop_pkg::PRD_W-1)'(-p_s2)
		: p_s2[scop_pkg::PRD_W-2:0];
	assign prod  = mag * scop_pkg::RECIP_200;

	always_comb begin
		sv = neg_s3 ? -$signed({1'b0, mq_s3}) : $signed({1'b0, mq_s3});
		if (sv > 17'sd32767) begin
			sat = 16'h7FFF;
		end else if (sv < -17'sd32768) begin
			sat = 16'h8000;
		end else begin
			sat = sv[scop_pkg::SMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sh_q  <= 1'b0;
			v_p1_q  <= 1'b0;
			v_p2_q  <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (free_sh) begin
				v_sh_q <= in_valid;
			end
			if (free_p1) begin
				v_p1_q <= v_sh_q;
			end
			if (free_p2) begin
				v_p2_q <= v_p1_q;
			end
			if (free_out) begin
				v_out_q <= v_p2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free_sh && in_valid) begin
			y_s1   <= y[13:0];
			byp_s1 <= in_data.byp;
			x_s1   <= in_data.x;
		end
		if (free_p1 && v_sh_q) begin
			p_s2   <= scop_pkg::PRD_W'(y_s1 * $signed({1'b0, scale}));
			byp_s2 <= byp_s1;
			x_s2   <= x_s1;
		end
		if (free_p2 && v_p1_q) begin
			mq_s3  <= prod[scop_pkg::RCP_SH+scop_pkg::SMP_W-1:scop_pkg::RCP_SH];
			neg_s3 <= p_s2[scop_pkg::PRD_W-1];
			byp_s3 <= byp_s2;
			x_s3   <= x_s2;
		end
		if (free_out && v_p2_q) begin
			out_q <= byp_s3 ? x_s3 : sat;
		end
	end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streaming testbench for the soft-clip overdrive.
// ----------------------------------------------------------------------------
// Samples are sent on the input stream under several register settings, and
// every output beat is checked against a local model of the clipping curve
// and gain. The settings include the register extremes, a zero clip level and
// a bypassed effect. Random gaps are placed on both sides of the stream, and
// one long stall on the output fills the pipeline.
// ----------------------------------------------------------------------------

class clip_scoreboard;
	logic signed [scop_pkg::SMP_W-1:0] pending_out[$];
	bit                                en;
	bit [scop_pkg::LVL_W-1:0]          clip;
	bit [scop_pkg::LVL_W-1:0]          gain;
	int                                errors;

	function new();
		en = 1'b0;
		clip = scop_pkg::CLIP_RST;
		gain = scop_pkg::GAIN_RST;
		errors = 0;
	endfunction

	function void set_reg(scop_pkg::reg_idx_t idx, logic [31:0] value);
		case (idx)
			scop_pkg::REG_ENABLE: en = value[0];
			scop_pkg::REG_CLIP:   clip = value[scop_pkg::LVL_W-1:0];
			scop_pkg::REG_GAIN:   gain = value[scop_pkg::LVL_W-1:0];
			default:              ;
		endcase
	endfunction

	function logic signed [scop_pkg::SMP_W-1:0] overdrive(
		logic signed [scop_pkg::SMP_W-1:0] x_in);
		int x;
		int t;
		int third;
		int two3;
		int y;
		int scale;
		x = x_in;
		if (!en)
			return x_in;
		t = 30 * int'(clip);
		third = t / 3;
		two3 = (2 * t) / 3;
		scale = 200 + 3 * int'(gain);
		if (x <= -two3)
			y = -t;
		else if (x <= -third)
			y = (t == 0) ? 2 * x : third + 4 * x + 3 * ((x * x) / t);
		else if (x < third)
			y = 2 * x;
		else if (x <= two3)
			y = (t == 0) ? 2 * x : -third + 4 * x - 3 * ((x * x) / t);
		else
			y = t;
		y = (y * scale) / 200;
		if (y > 32767)
			y = 32767;
		if (y < -32768)
			y = -32768;
		return y[scop_pkg::SMP_W-1:0];
	endfunction

	function void note_sample(logic signed [scop_pkg::SMP_W-1:0] x);
		pending_out.push_back(overdrive(x));
	endfunction

	function void check_sample(logic signed [scop_pkg::SMP_W-1:0] got);
		logic signed [scop_pkg::SMP_W-1:0] want;
		if (pending_out.size() == 0) begin
			errors++;
			$display("%0t: unexpected sample_out, expected none, actual %0d", $time, got);
		end else begin
			want = pending_out.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: sample_out mismatch, expected %0d, actual %0d",
					$time, want, got);
			end
		end
	endfunction
endclass

module tb;
	localparam int HOLD_CYCLES = 80;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 100;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [15:0] sample_in
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [15:0] sample_out
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	clip_scoreboard sb = new();
	int send_idle = 34;
	int recv_idle = 62;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;

	soft_clip_overdrive dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_sample(s_tdata);
		if (m_tvalid && m_tready)
			sb.check_sample(m_tdata);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL soft_clip_overdrive");
			$finish;
		end
	end

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic apb_write(scop_pkg::reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	task automatic apply_config(bit en, bit [scop_pkg::LVL_W-1:0] clip,
		bit [scop_pkg::LVL_W-1:0] gain);
		apb_write(scop_pkg::REG_ENABLE, ($urandom & ~32'h1) | en);
		apb_write(scop_pkg::REG_CLIP, ($urandom & ~32'h7F) | clip);
		apb_write(scop_pkg::REG_GAIN, ($urandom & ~32'h7F) | gain);
	endtask

	task automatic send_sample(int value);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value[15:0];
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_out.size() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_sample(int t);
		int knee;
		case ($urandom_range(9))
			0, 1, 2, 3: return int'($urandom_range(65535));
			4, 5, 6, 7: return int'($urandom_range(2 * t + 200)) - (t + 100);
			default: begin
				case ($urandom_range(3))
					0: knee = t / 3;
					1: knee = -(t / 3);
					2: knee = (2 * t) / 3;
					default: knee = -((2 * t) / 3);
				endcase
				return knee + int'($urandom_range(4)) - 2;
			end
		endcase
	endfunction

	initial begin
		int t;
		bit en;
		bit [scop_pkg::LVL_W-1:0] clip;
		bit [scop_pkg::LVL_W-1:0] gain;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bypass after reset, then the knee boundaries at the reset clip level.
		send_sample(-32768);
		send_sample(32767);
		send_sample(0);
		send_sample(-1);
		send_sample(1);
		drain();
		apb_write(scop_pkg::REG_ENABLE, 32'd1);
		t = 30 * int'(sb.clip);
		for (int d = -1; d <= 1; d++) begin
			send_sample(-((2 * t) / 3) + d);
			send_sample(-(t / 3) + d);
			send_sample(t / 3 + d);
			send_sample((2 * t) / 3 + d);
		end
		send_sample(-32768);
		send_sample(32767);
		send_sample(0);
		send_sample(-1);
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin en = 1'b1; clip = 7'd50;  gain = 7'd50;  end
				1: begin en = 1'b0; clip = 7'd99;  gain = 7'd99;  end
				2: begin en = 1'b1; clip = 7'd1;   gain = 7'd1;   end
				3: begin en = 1'b1; clip = 7'd99;  gain = 7'd99;  end
				4: begin en = 1'b1; clip = 7'd0;   gain = 7'd127; end
				5: begin en = 1'b1; clip = 7'd127; gain = 7'd0;   end
				6: begin
					en = 1'b1;
					clip = scop_pkg::LVL_W'($urandom_range(99, 1));
					gain = scop_pkg::LVL_W'($urandom_range(99, 1));
				end
				default: begin
					en = 1'b1;
					clip = scop_pkg::LVL_W'($urandom_range(127));
					gain = scop_pkg::LVL_W'($urandom_range(127));
				end
			endcase
			if (p < 3) begin
				send_idle = 34;
				recv_idle = 62;
			end else if (p < 6) begin
				send_idle = 62;
				recv_idle = 34;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			if (p == 3)
				apb_write(scop_pkg::REG_NONE, $urandom);
			apply_config(en, clip, gain);
			t = 30 * int'(clip);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 6 && i == 20)
					hold_req = 1'b1;
				if (p == 7 && i == 50)
					drain();
				send_sample(pick_sample(t));
			end
			drain();
		end

		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending_out.size() == 0)
			$display("PASS soft_clip_overdrive");
		else
			$display("FAIL soft_clip_overdrive");
		$finish;
	end
endmodule
